// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/stok_pkg.sv -----
// Package for the source tokenizer: kinds, codes, modes and result record
`default_nettype none
package stok_pkg;

    localparam int unsigned MaxKeywordChars = 9;
    localparam int unsigned OffsetBits      = 24;
    localparam int unsigned LineBits        = 20;
    localparam int unsigned ColumnBits      = 16;

    localparam logic [5:0] K_IDENT = 6'd20;
    localparam logic [5:0] K_INT   = 6'd21;
    localparam logic [5:0] K_STR   = 6'd22;
    localparam logic [5:0] K_LPAR  = 6'd23;
    localparam logic [5:0] K_RPAR  = 6'd24;
    localparam logic [5:0] K_LBR   = 6'd25;
    localparam logic [5:0] K_RBR   = 6'd26;
    localparam logic [5:0] K_SEMI  = 6'd27;
    localparam logic [5:0] K_COMMA = 6'd28;
    localparam logic [5:0] K_DOT   = 6'd29;
    localparam logic [5:0] K_PLUS  = 6'd30;
    localparam logic [5:0] K_MINUS = 6'd31;
    localparam logic [5:0] K_STAR  = 6'd32;
    localparam logic [5:0] K_PCT   = 6'd33;
    localparam logic [5:0] K_NOT   = 6'd34;
    localparam logic [5:0] K_NE    = 6'd35;
    localparam logic [5:0] K_ASGN  = 6'd36;
    localparam logic [5:0] K_EQ    = 6'd37;
    localparam logic [5:0] K_LT    = 6'd38;
    localparam logic [5:0] K_LE    = 6'd39;
    localparam logic [5:0] K_GT    = 6'd40;
    localparam logic [5:0] K_GE    = 6'd41;
    localparam logic [5:0] K_DIV   = 6'd42;
    localparam logic [5:0] K_AND   = 6'd43;
    localparam logic [5:0] K_OR    = 6'd44;
    localparam logic [5:0] K_END   = 6'd45;

    localparam logic [2:0] D_OPEN_COMMENT = 3'd0;
    localparam logic [2:0] D_OPEN_STRING  = 3'd1;
    localparam logic [2:0] D_LONE_AMP     = 3'd2;
    localparam logic [2:0] D_LONE_BAR     = 3'd3;
    localparam logic [2:0] D_UNKNOWN      = 3'd4;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_LINE, M_BLOCK, M_BLOCK_STAR, M_PENDING
    } t_mode;

    // Keyword text, NUL padded to 9 characters, index = kind
    typedef logic [8:0][7:0] t_kw;
    localparam int unsigned NumKeywords = 20;

    function automatic t_kw kw_text(input logic [4:0] k);
        t_kw t;
        t = '0;
        case (k)
            5'd0:  t[4:0] = {"s","s","a","l","c"};
            5'd1:  t[4:0] = {"g","n","i","s","u"};
            5'd2:  t[8:0] = {"e","c","a","p","s","e","m","a","n"};
            5'd3:  t[5:0] = {"c","i","l","b","u","p"};
            5'd4:  t[6:0] = {"e","t","a","v","i","r","p"};
            5'd5:  t[5:0] = {"c","i","t","a","t","s"};
            5'd6:  t[3:0] = {"d","i","o","v"};
            5'd7:  t[2:0] = {"t","n","i"};
            5'd8:  t[3:0] = {"l","o","o","b"};
            5'd9:  t[5:0] = {"g","n","i","r","t","s"};
            5'd10: t[5:0] = {"n","r","u","t","e","r"};
            5'd11: t[1:0] = {"f","i"};
            5'd12: t[3:0] = {"e","s","l","e"};
            5'd13: t[2:0] = {"r","o","f"};
            5'd14: t[4:0] = {"e","l","i","h","w"};
            5'd15: t[4:0] = {"k","a","e","r","b"};
            5'd16: t[7:0] = {"e","u","n","i","t","n","o","c"};
            5'd17: t[2:0] = {"w","e","n"};
            5'd18: t[3:0] = {"e","u","r","t"};
            5'd19: t[4:0] = {"e","s","l","a","f"};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Classified byte from the front end
    typedef struct packed {
        logic       eos;
        logic [7:0] ch;
        logic       alpha;
        logic       digit;
    } t_cls;

    // One result item, positions at full 32-bit width, cut at the top level
    typedef struct packed {
        logic [5:0]  kind;
        logic        isd;
        logic [2:0]  code;
        logic [7:0]  bad;
        logic [31:0] ln;
        logic [31:0] col;
        logic [31:0] off;
        logic [31:0] len;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

// ----- rtl/stok_front.sv -----
// Front end: accepts bytes and classifies them into a short queue
`default_nettype none
`include "assert_macros.svh"
module stok_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  wire  [7:0]          i_ch,
    input  wire                 i_end_of_source,
    output logic                o_valid,
    output stok_pkg::t_cls      o_cls,
    input  wire                 i_take
);
    import stok_pkg::*;

    // two-entry queue
    t_cls       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, take_ok;
    t_cls       cls;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cls   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_valid;

    always_comb begin
        cls.eos   = i_end_of_source;
        cls.ch    = i_ch;
        cls.alpha = is_alpha(i_ch);
        cls.digit = is_digit(i_ch);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= ~r_wp;
            if (take_ok) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, take_ok};
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, r_cnt == 2'd2, !push_ok, "queue overflow")
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !push_ok && !take_ok, $stable(r_cnt),
        "queue count moved")
endmodule
`default_nettype wire

// ----- rtl/stok_back.sv -----
// Back end: scanner state machine and result queue
`default_nettype none
`include "assert_macros.svh"
module stok_back #(
    parameter int unsigned MAX_KEYWORD_CHARS = stok_pkg::MaxKeywordChars,
    parameter int unsigned OFFSET_BITS       = stok_pkg::OffsetBits,
    parameter int unsigned LINE_BITS         = stok_pkg::LineBits,
    parameter int unsigned COLUMN_BITS       = stok_pkg::ColumnBits
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  stok_pkg::t_cls      i_cls,
    output logic                o_take,
    output logic                o_empty,
    output stok_pkg::t_res      o_res,
    input  wire                 i_pop
);
    import stok_pkg::*;

    localparam int unsigned KlW  = $clog2(MAX_KEYWORD_CHARS + 1);
    localparam int unsigned KiW  = $clog2(MAX_KEYWORD_CHARS);
    localparam int unsigned QD   = 4;

    t_mode                   r_mode, n_mode;
    logic [LINE_BITS-1:0]    r_line, n_line, r_sline, n_sline;
    logic [COLUMN_BITS-1:0]  r_col, n_col, r_scol, n_scol;
    logic [OFFSET_BITS-1:0]  r_off, n_off, r_soff, n_soff;
    logic [7:0]              r_pend, n_pend;
    logic [7:0]              r_kb [MAX_KEYWORD_CHARS];
    logic [KlW-1:0]          r_klen, n_klen;
    logic                    r_long, n_long;
    logic                    kb_we;
    logic [KiW-1:0]          kb_idx;

    // result queue (holds up to 4; one step emits at most 2)
    t_res       r_rq [QD];
    logic [1:0] r_rwp, r_rrp;
    logic [2:0] r_rcnt;
    t_res       e0, e1, e2;
    logic [1:0] ne;
    logic       go, pop_ok;

    assign pop_ok  = i_pop && !o_empty;
    assign o_empty = r_rcnt == 3'd0;
    assign o_res   = r_rq[r_rrp];
    assign o_take  = r_rcnt <= 3'd2 || (r_rcnt == 3'd3 && pop_ok);
    assign go      = i_valid && o_take;

    // keyword match on the buffered prefix
    function automatic logic [5:0] lookup(input logic [KlW-1:0] klen, input logic lng,
                                          input logic [MAX_KEYWORD_CHARS*8-1:0] kb);
        logic [5:0] k;
        t_kw        t;
        logic       ok;
        k = K_IDENT;
        for (int i = NumKeywords - 1; i >= 0; i--) begin
            t  = kw_text(5'(i));
            ok = 1'b1;
            for (int j = 0; j < MAX_KEYWORD_CHARS; j++) begin
                if (KlW'(j) < klen) begin
                    if (j >= 9 || t[j] != kb[j*8 +: 8]) ok = 1'b0;
                end else if (j < 9 && KlW'(j) == klen) begin
                    if (t[j] != 8'd0) ok = 1'b0;
                end
            end
            if (klen == KlW'(MAX_KEYWORD_CHARS) && MAX_KEYWORD_CHARS < 9) begin
                if (t[MAX_KEYWORD_CHARS % 9] != 8'd0) ok = 1'b0;
            end
            if (ok && !lng) k = 6'(i);
        end
        return k;
    endfunction

    logic [MAX_KEYWORD_CHARS*8-1:0] kb_flat;
    always_comb begin
        for (int j = 0; j < MAX_KEYWORD_CHARS; j++) kb_flat[j*8 +: 8] = r_kb[j];
    end

    always_comb begin
        t_res       r;
        logic [7:0] c;
        logic       rescan, idle_adv;
        logic [5:0] kd;
        logic [OFFSET_BITS-1:0] span;
        c = i_cls.ch;
        n_mode = r_mode; n_line = r_line; n_col = r_col; n_off = r_off;
        n_sline = r_sline; n_scol = r_scol; n_soff = r_soff;
        n_pend = r_pend; n_klen = r_klen; n_long = r_long;
        kb_we = 1'b0; kb_idx = '0;
        e0 = '0; e1 = '0; e2 = '0; ne = 2'd0;
        rescan = 1'b0; idle_adv = 1'b1;
        span = r_off - r_soff;
        kd = lookup(r_klen, r_long, kb_flat);
        r = '0;
        r.ln = 32'(r_sline); r.col = 32'(r_scol); r.off = 32'(r_soff);

        if (i_cls.eos) begin
            case (r_mode)
                M_IDENT:  begin r.kind = kd; r.len = 32'(span); end
                M_NUMBER: begin r.kind = K_INT; r.len = 32'(span); end
                M_STRING: begin r.isd = 1'b1; r.code = D_OPEN_STRING; end
                M_BLOCK, M_BLOCK_STAR: begin r.isd = 1'b1; r.code = D_OPEN_COMMENT; end
                M_PENDING: begin
                    case (r_pend)
                        "!": begin r.kind = K_NOT;  r.len = 32'd1; end
                        "=": begin r.kind = K_ASGN; r.len = 32'd1; end
                        "<": begin r.kind = K_LT;   r.len = 32'd1; end
                        ">": begin r.kind = K_GT;   r.len = 32'd1; end
                        "/": begin r.kind = K_DIV;  r.len = 32'd1; end
                        "&": begin r.isd = 1'b1; r.code = D_LONE_AMP; end
                        default: begin r.isd = 1'b1; r.code = D_LONE_BAR; end
                    endcase
                end
                default: ;
            endcase
            if (r_mode inside {M_IDENT, M_NUMBER, M_STRING, M_BLOCK, M_BLOCK_STAR,
                               M_PENDING}) begin
                e0 = r; ne = 2'd1;
            end
            r = '0;
            r.kind = K_END; r.ln = 32'(r_line); r.col = 32'(r_col); r.off = 32'(r_off);
            if (ne == 2'd0) e0 = r; else e1 = r;
            ne = ne + 2'd1;
            n_mode = M_IDLE; n_line = LINE_BITS'(1); n_col = COLUMN_BITS'(1);
            n_off = '0; n_soff = '0; n_sline = LINE_BITS'(1); n_scol = COLUMN_BITS'(1);
            n_pend = '0; n_klen = '0; n_long = 1'b0;
            idle_adv = 1'b0;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (i_cls.alpha || i_cls.digit) begin
                        if (r_klen < KlW'(MAX_KEYWORD_CHARS)) begin
                            kb_we = 1'b1; kb_idx = KiW'(r_klen); n_klen = r_klen + 1'b1;
                        end else n_long = 1'b1;
                    end else begin
                        r.kind = kd; r.len = 32'(span); e0 = r; ne = 2'd1; rescan = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (!i_cls.digit) begin
                        r.kind = K_INT; r.len = 32'(span); e0 = r; ne = 2'd1; rescan = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == "\"") begin
                        r.kind = K_STR;
                        r.len = 32'(((r_off == {OFFSET_BITS{1'b1}}) ? r_off : r_off + 1'b1)
                                    - r_soff);
                        e0 = r; ne = 2'd1; n_mode = M_IDLE;
                    end else if (c == "\n") begin
                        r.isd = 1'b1; r.code = D_OPEN_STRING; e0 = r; ne = 2'd1;
                        rescan = 1'b1;
                    end
                end
                M_LINE: if (c == "\n") rescan = 1'b1;
                M_BLOCK, M_BLOCK_STAR: begin
                    if (r_mode == M_BLOCK_STAR && c == "/") n_mode = M_IDLE;
                    else n_mode = (c == "*") ? M_BLOCK_STAR : M_BLOCK;
                end
                M_PENDING: begin
                    if (r_pend == "/" && c == "/") n_mode = M_LINE;
                    else if (r_pend == "/" && c == "*") n_mode = M_BLOCK;
                    else begin
                        r.len = 32'd2;
                        if (c == "=" && r_pend == "!") r.kind = K_NE;
                        else if (c == "=" && r_pend == "=") r.kind = K_EQ;
                        else if (c == "=" && r_pend == "<") r.kind = K_LE;
                        else if (c == "=" && r_pend == ">") r.kind = K_GE;
                        else if (c == "&" && r_pend == "&") r.kind = K_AND;
                        else if (c == "|" && r_pend == "|") r.kind = K_OR;
                        if (r.kind != 6'd0) begin
                            e0 = r; ne = 2'd1; n_mode = M_IDLE;
                        end else begin
                            r.len = 32'd1;
                            case (r_pend)
                                "!": r.kind = K_NOT;
                                "=": r.kind = K_ASGN;
                                "<": r.kind = K_LT;
                                ">": r.kind = K_GT;
                                "/": r.kind = K_DIV;
                                "&": begin r.isd = 1'b1; r.code = D_LONE_AMP; r.len = '0; end
                                default: begin
                                    r.isd = 1'b1; r.code = D_LONE_BAR; r.len = '0;
                                end
                            endcase
                            e0 = r; ne = 2'd1; rescan = 1'b1;
                        end
                    end
                end
                default: rescan = 1'b1;
            endcase

            if (rescan) begin
                n_mode = M_IDLE;
                n_soff = r_off; n_sline = r_line; n_scol = r_col;
                r = '0;
                r.ln = 32'(r_line); r.col = 32'(r_col); r.off = 32'(r_off); r.len = 32'd1;
                case (c)
                    " ", "\t", "\r", "\n": ;
                    "\"": n_mode = M_STRING;
                    "(": r.kind = K_LPAR;
                    ")": r.kind = K_RPAR;
                    "{": r.kind = K_LBR;
                    "}": r.kind = K_RBR;
                    ";": r.kind = K_SEMI;
                    ",": r.kind = K_COMMA;
                    ".": r.kind = K_DOT;
                    "+": r.kind = K_PLUS;
                    "-": r.kind = K_MINUS;
                    "*": r.kind = K_STAR;
                    "%": r.kind = K_PCT;
                    "!", "=", "<", ">", "/", "&", "|": begin
                        n_pend = c; n_mode = M_PENDING;
                    end
                    default: begin
                        if (i_cls.alpha) begin
                            n_mode = M_IDENT; n_long = 1'b0; n_klen = KlW'(1);
                            kb_we = 1'b1; kb_idx = '0;
                        end else if (i_cls.digit) n_mode = M_NUMBER;
                        else begin
                            r.isd = 1'b1; r.code = D_UNKNOWN; r.bad = c; r.len = '0;
                        end
                    end
                endcase
                if (r.kind != 6'd0 || r.isd) begin
                    if (ne == 2'd0) e0 = r; else e1 = r;
                    ne = ne + 2'd1;
                end
            end
        end

        if (idle_adv) begin
            if (c == "\n") begin
                n_line = (r_line == {LINE_BITS{1'b1}}) ? r_line : r_line + 1'b1;
                n_col  = COLUMN_BITS'(1);
            end else begin
                n_col = (r_col == {COLUMN_BITS{1'b1}}) ? r_col : r_col + 1'b1;
            end
            n_off = (r_off == {OFFSET_BITS{1'b1}}) ? r_off : r_off + 1'b1;
        end
        case (ne)
            2'd1: e0.last = 1'b1;
            2'd2: e1.last = 1'b1;
            2'd3: e2.last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (go && kb_we) r_kb[kb_idx] <= i_cls.ch;
        if (go) begin
            if (ne >= 2'd1) r_rq[r_rwp] <= e0;
            if (ne >= 2'd2) r_rq[r_rwp + 2'd1] <= e1;
            if (ne >= 2'd3) r_rq[r_rwp + 2'd2] <= e2;
        end
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= LINE_BITS'(1); r_col <= COLUMN_BITS'(1);
            r_off <= '0; r_soff <= '0; r_sline <= LINE_BITS'(1);
            r_scol <= COLUMN_BITS'(1); r_pend <= '0; r_klen <= '0; r_long <= 1'b0;
            r_rwp <= '0; r_rrp <= '0; r_rcnt <= '0;
        end else begin
            if (go) begin
                r_mode <= n_mode; r_line <= n_line; r_col <= n_col; r_off <= n_off;
                r_soff <= n_soff; r_sline <= n_sline; r_scol <= n_scol;
                r_pend <= n_pend; r_klen <= n_klen; r_long <= n_long;
                r_rwp <= r_rwp + ne;
            end
            if (pop_ok) r_rrp <= r_rrp + 2'd1;
            r_rcnt <= r_rcnt + (go ? {1'b0, ne} : 3'd0) - {2'b0, pop_ok};
        end
    end

    `ASSERT_IMPL(a_room, i_clk, i_rst_n, go, r_rcnt - {2'b0, pop_ok} <= 3'd2,
        "result queue short of room")
    `ASSERT_NEXT(a_idle_after_end, i_clk, i_rst_n, go && i_cls.eos,
        r_mode == M_IDLE && r_off == '0, "state not cleared after end")
    `ASSERT_IMPL(a_emits, i_clk, i_rst_n, go && i_cls.eos, ne != 2'd0,
        "end gave no token")
endmodule
`default_nettype wire

// ----- rtl/source_tokenizer_unit.sv -----
// Top level of the source tokenizer
`default_nettype none
// Source tokenizer.
// Input queue: drive i_ch and i_end_of_source, raise push while full is
// low; one byte (or the end marker) is taken per edge.
// Result queue: while empty is low the oldest token or diagnostic stands on
// the o_ ports; raise pop to take it. o_last_of_run marks the final result
// produced by one input.
// A byte passes a two-entry classify queue and is then scanned, which writes
// its results to the result queue, from where they can be popped. One byte per
// cycle is sustained while results drain at least as fast as they are made;
// the scanner waits when the four-entry result queue cannot take a worst case
// of two more, and the input queue then fills and raises full.
// The end marker flushes any pending token, gives the end token and returns
// all counters to line 1, column 1, offset 0 for the next source.
// Reset (synchronous, active low) empties both queues and the scanner state.
// A stalled receiver holds the head result steady until it is popped.
module source_tokenizer_unit #(
    parameter int unsigned MAX_KEYWORD_CHARS = stok_pkg::MaxKeywordChars,
    parameter int unsigned OFFSET_BITS       = stok_pkg::OffsetBits,
    parameter int unsigned LINE_BITS         = stok_pkg::LineBits,
    parameter int unsigned COLUMN_BITS       = stok_pkg::ColumnBits
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    push,
    output logic                   full,
    input  wire  [7:0]             i_ch,
    input  wire                    i_end_of_source,
    output logic                   empty,
    input  wire                    pop,
    output logic [5:0]             o_token_kind,
    output logic                   o_is_diagnostic,
    output logic [2:0]             o_diag_code,
    output logic [7:0]             o_bad_char,
    output logic [LINE_BITS-1:0]   o_line,
    output logic [COLUMN_BITS-1:0] o_column,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [OFFSET_BITS-1:0] o_length,
    output logic                   o_last_of_run
);
    import stok_pkg::*;

    logic valid, take;
    t_cls cls;
    t_res res;

    stok_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_ch, .i_end_of_source,
        .o_valid(valid), .o_cls(cls), .i_take(take)
    );

    stok_back #(
        .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS), .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_valid(valid), .i_cls(cls), .o_take(take),
        .o_empty(empty), .o_res(res), .i_pop(pop)
    );

    assign o_token_kind    = res.kind;
    assign o_is_diagnostic = res.isd;
    assign o_diag_code     = res.code;
    assign o_bad_char      = res.bad;
    assign o_line          = res.ln[LINE_BITS-1:0];
    assign o_column        = res.col[COLUMN_BITS-1:0];
    assign o_offset        = res.off[OFFSET_BITS-1:0];
    assign o_length        = res.len[OFFSET_BITS-1:0];
    assign o_last_of_run   = res.last;
endmodule
`default_nettype wire
